FILE: rtl/device_health_alert_monitor_assert.svh
// Assertion macros shared by the device health alert monitor RTL.
`ifndef DEVICE_HEALTH_ALERT_MONITOR_ASSERT_SVH
`define DEVICE_HEALTH_ALERT_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DHAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DHAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dham_pkg.sv
// Types, codes and constants of the device health alert monitor.
`timescale 1ns / 1ps
package dham_pkg;

    localparam int DEVICE_COUNT = 5;
    localparam int SLOT_COUNT   = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET    = 16'd3000;
    localparam logic [15:0] PERIOD_RESET     = 16'd1000;
    localparam logic [7:0]  CONV_MASK_RESET  = 8'hFB;
    localparam logic [7:0]  CRIT_LEVEL_RESET = 8'd2;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_BATTERY   = 3'd1,
        MODE_CHARGER   = 3'd2,
        MODE_CONVERTER = 3'd3,
        MODE_RADIO     = 3'd4,
        MODE_BACKUP    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        REG_TIMEOUT    = 2'd0,
        REG_PERIOD     = 2'd1,
        REG_CONV_MASK  = 2'd2,
        REG_CRIT_LEVEL = 2'd3
    } t_reg_idx;

    localparam logic [2:0] DEV_BATTERY   = 3'd0;
    localparam logic [2:0] DEV_CHARGER   = 3'd1;
    localparam logic [2:0] DEV_CONVERTER = 3'd2;
    localparam logic [2:0] DEV_RADIO     = 3'd3;
    localparam logic [2:0] DEV_BACKUP    = 3'd4;

    localparam logic [1:0] SEV_INFO = 2'd0;
    localparam logic [1:0] SEV_WARN = 2'd1;
    localparam logic [1:0] SEV_CRIT = 2'd2;

    localparam logic [2:0] KIND_STATUS  = 3'd0;
    localparam logic [2:0] KIND_OFFLINE = 3'd1;
    localparam logic [2:0] KIND_ONLINE  = 3'd2;
    localparam logic [2:0] KIND_SERIAL  = 3'd3;
    localparam logic [2:0] KIND_TEMP    = 3'd4;
    localparam logic [2:0] KIND_NODE    = 3'd5;

    typedef struct packed {
        logic [15:0] timeout;
        logic [15:0] period;
        logic [7:0]  conv_mask;
        logic [7:0]  crit_level;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  device;
        logic [1:0]  severity;
        logic [15:0] code;
        logic        active;
        logic [2:0]  kind;
    } t_alert;

    // One job: the alerts of one item, sent lowest slot first.
    typedef struct packed {
        logic [SLOT_COUNT-1:0]          mask;
        t_alert [SLOT_COUNT-1:0]        slot;
    } t_job;

    function automatic t_alert mk_alert(input logic [2:0] dev, input logic [1:0] sev,
                                        input logic [15:0] code, input logic act,
                                        input logic [2:0] kind);
        t_alert a;
        a.device   = dev;
        a.severity = sev;
        a.code     = code;
        a.active   = act;
        a.kind     = kind;
        return a;
    endfunction

endpackage

FILE: rtl/dham_queue.sv
// Short job queue between the classifying front end and the alert back end.
`timescale 1ns / 1ps
`include "device_health_alert_monitor_assert.svh"
module dham_queue
    import dham_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `DHAM_ASSERT_IMP(a_no_overflow, i_push, r_count < CNT_FULL, "job queue overflow")
    `DHAM_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0, "job queue underflow")

endmodule

FILE: rtl/dham_front.sv
// Front end: accepts items, keeps device state and builds alert jobs.
`timescale 1ns / 1ps
module dham_front
    import dham_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_alarm_level,
    input  logic [31:0] i_fault_word,
    input  logic [31:0] i_alarm_word,
    input  logic [31:0] i_protect_word,
    input  logic        i_serial_online,
    input  logic [15:0] i_alarm_count,
    input  logic [7:0]  i_node_count,
    input  logic [7:0]  i_online_count,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam int CMP_W = (AGE_BITS > 16) ? AGE_BITS : 16;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    logic [AGE_BITS-1:0]     r_age [DEVICE_COUNT];
    logic [AGE_BITS-1:0]     n_age [DEVICE_COUNT];
    logic [AGE_BITS-1:0]     age_inc [DEVICE_COUNT];
    logic [DEVICE_COUNT-1:0] r_seen, n_seen;
    logic [DEVICE_COUNT-1:0] r_online, n_online;
    logic [DEVICE_COUNT-1:0] now_on;
    logic [15:0]             r_period, n_period;
    logic [15:0]             period_next, period_eff;
    logic [7:0]              r_prev_level, n_prev_level;
    logic [15:0]             r_prev_chg, n_prev_chg;
    logic                    r_prev_conv, n_prev_conv;
    logic                    r_prev_serial, n_prev_serial;
    logic [15:0]             r_prev_temp, n_prev_temp;
    logic                    r_prev_missing, n_prev_missing;
    logic                    r_prev_backup, n_prev_backup;
    logic                    accept;
    logic                    conv_fault, nodes_missing, backup_abn;
    logic [15:0]             missing_code;
    t_job                    job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Saturating ages and their online judgment, one lane per device.
    always_comb begin
        for (int i = 0; i < DEVICE_COUNT; i++) begin
            age_inc[i] = (r_age[i] == AGE_MAX) ? r_age[i] : r_age[i] + AGE_ONE;
            now_on[i]  = CMP_W'(age_inc[i]) <= CMP_W'(i_cfg.timeout);
        end
    end

    assign period_next   = r_period + 16'd1;
    assign period_eff    = (i_cfg.period == 16'd0) ? 16'd1 : i_cfg.period;
    assign conv_fault    = |(i_fault_word[7:0] & i_cfg.conv_mask);
    assign nodes_missing = (i_node_count != 8'd0) && (i_online_count < i_node_count);
    assign missing_code  = {8'd0, i_node_count - i_online_count};
    assign backup_abn    = (i_alarm_word != 32'd0) || (i_protect_word != 32'd0)
                           || (i_fault_word != 32'd0);

    always_comb begin
        n_age          = r_age;
        n_seen         = r_seen;
        n_online       = r_online;
        n_period       = r_period;
        n_prev_level   = r_prev_level;
        n_prev_chg     = r_prev_chg;
        n_prev_conv    = r_prev_conv;
        n_prev_serial  = r_prev_serial;
        n_prev_temp    = r_prev_temp;
        n_prev_missing = r_prev_missing;
        n_prev_backup  = r_prev_backup;
        job            = '0;
        if (accept) begin
            unique case (i_mode)
                MODE_TICK: begin
                    n_age    = age_inc;
                    n_period = period_next;
                    if (period_next >= period_eff) begin
                        n_period = 16'd0;
                        for (int i = 0; i < DEVICE_COUNT; i++) begin
                            if (r_seen[i] && (now_on[i] != r_online[i])) begin
                                n_online[i]  = now_on[i];
                                job.mask[i]  = 1'b1;
                                job.slot[i]  = now_on[i]
                                    ? mk_alert(3'(i), SEV_INFO, 16'd0, 1'b0, KIND_ONLINE)
                                    : mk_alert(3'(i), SEV_WARN, 16'd0, 1'b1, KIND_OFFLINE);
                            end
                        end
                    end
                end
                MODE_BATTERY: begin
                    n_age[DEV_BATTERY]  = '0;
                    n_seen[DEV_BATTERY] = 1'b1;
                    if (i_alarm_level != r_prev_level) begin
                        n_prev_level = i_alarm_level;
                        job.mask[0]  = 1'b1;
                        job.slot[0]  = mk_alert(DEV_BATTERY,
                            (i_alarm_level >= i_cfg.crit_level) ? SEV_CRIT : SEV_WARN,
                            i_fault_word[15:0], i_alarm_level != 8'd0, KIND_STATUS);
                    end
                end
                MODE_CHARGER: begin
                    n_age[DEV_CHARGER]  = '0;
                    n_seen[DEV_CHARGER] = 1'b1;
                    if (i_fault_word[15:0] != r_prev_chg) begin
                        n_prev_chg  = i_fault_word[15:0];
                        job.mask[0] = 1'b1;
                        job.slot[0] = mk_alert(DEV_CHARGER,
                            (i_fault_word[15:0] != 16'd0) ? SEV_WARN : SEV_INFO,
                            i_fault_word[15:0], i_fault_word[15:0] != 16'd0, KIND_STATUS);
                    end
                end
                MODE_CONVERTER: begin
                    n_age[DEV_CONVERTER]  = '0;
                    n_seen[DEV_CONVERTER] = 1'b1;
                    if (conv_fault != r_prev_conv) begin
                        n_prev_conv = conv_fault;
                        job.mask[0] = 1'b1;
                        job.slot[0] = mk_alert(DEV_CONVERTER,
                            conv_fault ? SEV_CRIT : SEV_INFO,
                            i_fault_word[15:0], conv_fault, KIND_STATUS);
                    end
                end
                MODE_RADIO: begin
                    n_age[DEV_RADIO]  = '0;
                    n_seen[DEV_RADIO] = 1'b1;
                    // Slot order gives the delivery order: serial, temperature, nodes.
                    if (i_serial_online != r_prev_serial) begin
                        n_prev_serial = i_serial_online;
                        job.mask[0]   = 1'b1;
                        job.slot[0]   = mk_alert(DEV_RADIO,
                            i_serial_online ? SEV_INFO : SEV_WARN,
                            16'd0, !i_serial_online, KIND_SERIAL);
                    end
                    if (i_alarm_count != r_prev_temp) begin
                        n_prev_temp = i_alarm_count;
                        job.mask[1] = 1'b1;
                        job.slot[1] = (i_alarm_count != 16'd0)
                            ? mk_alert(DEV_RADIO, SEV_WARN, i_alarm_count, 1'b1, KIND_TEMP)
                            : mk_alert(DEV_RADIO, SEV_INFO, 16'd0, 1'b0, KIND_TEMP);
                    end
                    if (nodes_missing != r_prev_missing) begin
                        n_prev_missing = nodes_missing;
                        job.mask[2]    = 1'b1;
                        job.slot[2]    = nodes_missing
                            ? mk_alert(DEV_RADIO, SEV_WARN, missing_code, 1'b1, KIND_NODE)
                            : mk_alert(DEV_RADIO, SEV_INFO, 16'd0, 1'b0, KIND_NODE);
                    end
                end
                MODE_BACKUP: begin
                    n_age[DEV_BACKUP]  = '0;
                    n_seen[DEV_BACKUP] = 1'b1;
                    if (backup_abn != r_prev_backup) begin
                        n_prev_backup = backup_abn;
                        job.mask[0]   = 1'b1;
                        job.slot[0]   = mk_alert(DEV_BACKUP,
                            backup_abn ? SEV_WARN : SEV_INFO,
                            i_fault_word[15:0], backup_abn, KIND_STATUS);
                    end
                end
                default: begin
                    // Unused modes change nothing.
                end
            endcase
        end
    end

    assign o_push = accept && (job.mask != '0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEVICE_COUNT; i++) begin
                r_age[i] <= '0;
            end
            r_seen         <= '0;
            r_online       <= '0;
            r_period       <= '0;
            r_prev_level   <= '0;
            r_prev_chg     <= '0;
            r_prev_conv    <= 1'b0;
            r_prev_serial  <= 1'b0;
            r_prev_temp    <= '0;
            r_prev_missing <= 1'b0;
            r_prev_backup  <= 1'b0;
        end else begin
            r_age          <= n_age;
            r_seen         <= n_seen;
            r_online       <= n_online;
            r_period       <= n_period;
            r_prev_level   <= n_prev_level;
            r_prev_chg     <= n_prev_chg;
            r_prev_conv    <= n_prev_conv;
            r_prev_serial  <= n_prev_serial;
            r_prev_temp    <= n_prev_temp;
            r_prev_missing <= n_prev_missing;
            r_prev_backup  <= n_prev_backup;
        end
    end

endmodule

FILE: rtl/dham_back.sv
// Back end: takes jobs from the queue and sends their alerts one per cycle while i_ready is high.
`timescale 1ns / 1ps
`include "device_health_alert_monitor_assert.svh"
module dham_back
    import dham_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_data,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_device,
    output logic [1:0]  o_severity,
    output logic [15:0] o_alert_code,
    output logic        o_active,
    output logic [2:0]  o_kind,
    output logic        o_last
);

    logic [SLOT_COUNT-1:0] r_mask, n_mask;
    t_alert [SLOT_COUNT-1:0] r_slot;
    logic [SLOT_COUNT-1:0] pick, rest;
    t_alert                cur;
    logic                  xfer, load;

    // Lowest pending slot goes first.
    always_comb begin
        pick = '0;
        cur  = r_slot[0];
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = '0;
                pick[i] = 1'b1;
                cur  = r_slot[i];
            end
        end
    end

    assign rest    = r_mask & ~pick;
    assign o_valid = (r_mask != '0);
    assign o_last  = (rest == '0);
    assign xfer    = o_valid && i_ready;
    assign load    = i_q_valid && (!o_valid || (xfer && o_last));
    assign o_q_pop = load;

    assign o_device     = cur.device;
    assign o_severity   = cur.severity;
    assign o_alert_code = cur.code;
    assign o_active     = cur.active;
    assign o_kind       = cur.kind;

    always_comb begin
        n_mask = r_mask;
        if (load) begin
            n_mask = i_q_data.mask;
        end else if (xfer) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_slot <= i_q_data.slot;
        end
    end

    `DHAM_ASSERT_NXT(a_job_continues, xfer && !o_last, o_valid, "job dropped before last alert")
    `DHAM_ASSERT_NXT(a_load_nonempty, load, o_valid, "empty job taken from queue")

endmodule

FILE: rtl/device_health_alert_monitor.sv
// Top level of the device health alert monitor: register port and block wiring.
`timescale 1ns / 1ps
// Device health alert monitor for five devices (battery, charger, converter,
// radio summary, backup battery). Each input transfer is a tick or one device's
// status message; the block answers with zero to five alert transfers, the
// final one of each item flagged by o_last. The front end takes one item per
// cycle whenever its two-entry job queue has room, updates the device ages,
// seen and online flags and remembered statuses at once, and queues the item's
// alerts as one job. The back end drains jobs and sends one alert per cycle
// while i_ready is high, one transfer per alert (five at most, after a
// completed check period); items without alerts never reach the queue.
// The output serializer therefore sets the sustained rate.
// Registers sit on the APB port at byte addresses 0 (timeout_ticks),
// 4 (check_period_ticks), 8 (converter_fault_mask), 12 (critical_alarm_level);
// write them only while no item is in flight. pready is always high.
module device_health_alert_monitor
    import dham_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_alarm_level,
    input  logic [31:0] i_fault_word,
    input  logic [31:0] i_alarm_word,
    input  logic [31:0] i_protect_word,
    input  logic        i_serial_online,
    input  logic [15:0] i_alarm_count,
    input  logic [7:0]  i_node_count,
    input  logic [7:0]  i_online_count,
    // alerts
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_device,
    output logic [1:0]  o_severity,
    output logic [15:0] o_alert_code,
    output logic        o_active,
    output logic [2:0]  o_kind,
    output logic        o_last
);

    t_cfg     r_cfg, n_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     q_push, q_pop, q_full, q_valid;
    t_job     q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    // Write lands in the access phase.
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_TIMEOUT:    n_cfg.timeout    = pwdata[15:0];
                REG_PERIOD:     n_cfg.period     = pwdata[15:0];
                REG_CONV_MASK:  n_cfg.conv_mask  = pwdata[7:0];
                REG_CRIT_LEVEL: n_cfg.crit_level = pwdata[7:0];
            endcase
        end
    end

    // Read back, zero-extended to the bus.
    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT:    prdata = {16'd0, r_cfg.timeout};
            REG_PERIOD:     prdata = {16'd0, r_cfg.period};
            REG_CONV_MASK:  prdata = {24'd0, r_cfg.conv_mask};
            REG_CRIT_LEVEL: prdata = {24'd0, r_cfg.crit_level};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout    <= TIMEOUT_RESET;
            r_cfg.period     <= PERIOD_RESET;
            r_cfg.conv_mask  <= CONV_MASK_RESET;
            r_cfg.crit_level <= CRIT_LEVEL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Classify items and hold device state.
    dham_front #(
        .AGE_BITS (AGE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_alarm_level   (i_alarm_level),
        .i_fault_word    (i_fault_word),
        .i_alarm_word    (i_alarm_word),
        .i_protect_word  (i_protect_word),
        .i_serial_online (i_serial_online),
        .i_alarm_count   (i_alarm_count),
        .i_node_count    (i_node_count),
        .i_online_count  (i_online_count),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (q_in)
    );

    // Decouple the two sides.
    dham_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Serialize each job's alerts onto the output channel.
    dham_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_out),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_device     (o_device),
        .o_severity   (o_severity),
        .o_alert_code (o_alert_code),
        .o_active     (o_active),
        .o_kind       (o_kind),
        .o_last       (o_last)
    );

endmodule

FILE: dv/dham_alert_checker.sv
// Alert checker: predicts the alerts of each accepted status transfer and compares them.
`timescale 1ns / 1ps
module dham_alert_checker
    import dham_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_alarm_level,
    input  logic [31:0] i_fault_word,
    input  logic [31:0] i_alarm_word,
    input  logic [31:0] i_protect_word,
    input  logic        i_serial_online,
    input  logic [15:0] i_alarm_count,
    input  logic [7:0]  i_node_count,
    input  logic [7:0]  i_online_count,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_device,
    input  logic [1:0]  i_severity,
    input  logic [15:0] i_alert_code,
    input  logic        i_active,
    input  logic [2:0]  i_kind,
    input  logic        i_last,
    input  logic        i_end_check,
    output int          o_pending,
    output int          o_fail_count
);

    localparam logic [15:0] AGE_SATURATED = 16'hFFFF;

    typedef struct packed {
        t_alert alert;
        logic   last;
    } t_expected_alert;

    t_expected_alert pending_alerts[$];

    // Register copies
    logic [15:0] cfg_timeout;
    logic [15:0] cfg_period;
    logic [7:0]  cfg_mask;
    logic [7:0]  cfg_crit;

    // Device tracking and remembered statuses
    logic [15:0] dev_age    [DEVICE_COUNT];
    logic        dev_seen   [DEVICE_COUNT];
    logic        dev_online [DEVICE_COUNT];
    logic [15:0] tick_count;
    logic [7:0]  last_level;
    logic [15:0] last_chg;
    logic        last_conv;
    logic        last_serial;
    logic [15:0] last_temp;
    logic        last_missing;
    logic        last_backup;

    function automatic t_alert alert_of(input logic [2:0] dev, input logic [1:0] sev,
                                        input logic [15:0] code, input logic act,
                                        input logic [2:0] kind);
        t_alert a;
        a.device   = dev;
        a.severity = sev;
        a.code     = code;
        a.active   = act;
        a.kind     = kind;
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] alert check: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic mark_seen(input int dev);
        dev_age[dev]  = 16'd0;
        dev_seen[dev] = 1'b1;
    endtask

    // Update the tracked state for one status transfer and queue its alerts.
    task automatic predict_alerts();
        t_alert          batch[$];
        t_expected_alert entry;
        logic [15:0]     period;
        logic [15:0]     chg;
        logic            now_on;
        logic            fault;
        logic            missing;
        logic            abnormal;
        case (i_mode)
            MODE_TICK: begin
                period = (cfg_period == 16'd0) ? 16'd1 : cfg_period;
                for (int d = 0; d < DEVICE_COUNT; d++) begin
                    if (dev_age[d] != AGE_SATURATED) dev_age[d] = dev_age[d] + 16'd1;
                end
                tick_count = tick_count + 16'd1;
                if (tick_count >= period) begin
                    tick_count = 16'd0;
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (dev_seen[d]) begin
                            now_on = (dev_age[d] <= cfg_timeout);
                            if (now_on != dev_online[d]) begin
                                dev_online[d] = now_on;
                                if (now_on) begin
                                    batch.push_back(alert_of(3'(d), SEV_INFO, 16'd0, 1'b0,
                                                             KIND_ONLINE));
                                end else begin
                                    batch.push_back(alert_of(3'(d), SEV_WARN, 16'd0, 1'b1,
                                                             KIND_OFFLINE));
                                end
                            end
                        end
                    end
                end
            end
            MODE_BATTERY: begin
                mark_seen(DEV_BATTERY);
                if (i_alarm_level != last_level) begin
                    batch.push_back(alert_of(DEV_BATTERY,
                                             (i_alarm_level >= cfg_crit) ? SEV_CRIT : SEV_WARN,
                                             i_fault_word[15:0], i_alarm_level != 8'd0,
                                             KIND_STATUS));
                    last_level = i_alarm_level;
                end
            end
            MODE_CHARGER: begin
                mark_seen(DEV_CHARGER);
                chg = i_fault_word[15:0];
                if (chg != last_chg) begin
                    batch.push_back(alert_of(DEV_CHARGER, (chg != 16'd0) ? SEV_WARN : SEV_INFO,
                                             chg, chg != 16'd0, KIND_STATUS));
                    last_chg = chg;
                end
            end
            MODE_CONVERTER: begin
                mark_seen(DEV_CONVERTER);
                fault = |(i_fault_word[7:0] & cfg_mask);
                if (fault != last_conv) begin
                    batch.push_back(alert_of(DEV_CONVERTER, fault ? SEV_CRIT : SEV_INFO,
                                             i_fault_word[15:0], fault, KIND_STATUS));
                    last_conv = fault;
                end
            end
            MODE_RADIO: begin
                mark_seen(DEV_RADIO);
                missing = (i_node_count != 8'd0) && (i_online_count < i_node_count);
                if (i_serial_online != last_serial) begin
                    batch.push_back(alert_of(DEV_RADIO, i_serial_online ? SEV_INFO : SEV_WARN,
                                             16'd0, !i_serial_online, KIND_SERIAL));
                    last_serial = i_serial_online;
                end
                if (i_alarm_count != last_temp) begin
                    if (i_alarm_count != 16'd0) begin
                        batch.push_back(alert_of(DEV_RADIO, SEV_WARN, i_alarm_count, 1'b1,
                                                 KIND_TEMP));
                    end else begin
                        batch.push_back(alert_of(DEV_RADIO, SEV_INFO, 16'd0, 1'b0, KIND_TEMP));
                    end
                    last_temp = i_alarm_count;
                end
                if (missing != last_missing) begin
                    last_missing = missing;
                    if (missing) begin
                        batch.push_back(alert_of(DEV_RADIO, SEV_WARN,
                                                 {8'd0, i_node_count - i_online_count}, 1'b1,
                                                 KIND_NODE));
                    end else begin
                        batch.push_back(alert_of(DEV_RADIO, SEV_INFO, 16'd0, 1'b0, KIND_NODE));
                    end
                end
            end
            MODE_BACKUP: begin
                mark_seen(DEV_BACKUP);
                abnormal = (i_alarm_word != 32'd0) || (i_protect_word != 32'd0) ||
                           (i_fault_word != 32'd0);
                if (abnormal != last_backup) begin
                    batch.push_back(alert_of(DEV_BACKUP, abnormal ? SEV_WARN : SEV_INFO,
                                             i_fault_word[15:0], abnormal, KIND_STATUS));
                    last_backup = abnormal;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < batch.size(); k++) begin
            entry.alert = batch[k];
            entry.last  = (k == batch.size() - 1);
            pending_alerts.push_back(entry);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_expected_alert want;
        if (!i_rst_n) begin
            cfg_timeout  = TIMEOUT_RESET;
            cfg_period   = PERIOD_RESET;
            cfg_mask     = CONV_MASK_RESET;
            cfg_crit     = CRIT_LEVEL_RESET;
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                dev_age[d]    = 16'd0;
                dev_seen[d]   = 1'b0;
                dev_online[d] = 1'b0;
            end
            tick_count   = 16'd0;
            last_level   = 8'd0;
            last_chg     = 16'd0;
            last_conv    = 1'b0;
            last_serial  = 1'b0;
            last_temp    = 16'd0;
            last_missing = 1'b0;
            last_backup  = 1'b0;
            pending_alerts.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_TIMEOUT:    cfg_timeout = i_pwdata[15:0];
                    REG_PERIOD:     cfg_period  = i_pwdata[15:0];
                    REG_CONV_MASK:  cfg_mask    = i_pwdata[7:0];
                    REG_CRIT_LEVEL: cfg_crit    = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_alerts();
            if (i_out_valid && i_out_ready) begin
                if (pending_alerts.size() == 0) begin
                    report_mismatch($sformatf("alert with nothing expected: device %0d kind %0d",
                                              i_device, i_kind));
                end else begin
                    want = pending_alerts.pop_front();
                    if (i_device !== want.alert.device)
                        report_mismatch($sformatf("device %0d, expected %0d (kind %0d)",
                                                  i_device, want.alert.device, want.alert.kind));
                    if (i_severity !== want.alert.severity)
                        report_mismatch($sformatf("dev %0d kind %0d: severity %0d, expected %0d",
                                                  want.alert.device, want.alert.kind,
                                                  i_severity, want.alert.severity));
                    if (i_alert_code !== want.alert.code)
                        report_mismatch($sformatf("dev %0d kind %0d: code %h, expected %h",
                                                  want.alert.device, want.alert.kind,
                                                  i_alert_code, want.alert.code));
                    if (i_active !== want.alert.active)
                        report_mismatch($sformatf("dev %0d kind %0d: active %0d, expected %0d",
                                                  want.alert.device, want.alert.kind,
                                                  i_active, want.alert.active));
                    if (i_kind !== want.alert.kind)
                        report_mismatch($sformatf("dev %0d: kind %0d, expected %0d",
                                                  want.alert.device, i_kind, want.alert.kind));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("dev %0d kind %0d: last %0d, expected %0d",
                                                  want.alert.device, want.alert.kind,
                                                  i_last, want.last));
                end
            end
            if (i_end_check && pending_alerts.size() != 0) begin
                report_mismatch($sformatf("%0d alerts never sent", pending_alerts.size()));
                pending_alerts.delete();
            end
        end
        o_pending = pending_alerts.size();
    end

endmodule

FILE: dv/tb_device_health_alert_monitor.sv
// Testbench top: stimulus, idling and verdict for the device health alert monitor.
`timescale 1ns / 1ps
module tb_device_health_alert_monitor;
    import dham_pkg::*;

    // Modes that the block must ignore
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int TAIL_CYCLES    = 20;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 59;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  level;
        logic [31:0] fault;
        logic [31:0] alarm;
        logic [31:0] protect;
        logic        serial;
        logic [15:0] acount;
        logic [7:0]  nodes;
        logic [7:0]  online;
    } t_status_item;

    // Block inputs, known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = 4'd0;
    logic [31:0] pwdata          = 32'd0;
    logic        i_valid         = 1'b0;
    logic [2:0]  i_mode          = 3'd0;
    logic [7:0]  i_alarm_level   = 8'd0;
    logic [31:0] i_fault_word    = 32'd0;
    logic [31:0] i_alarm_word    = 32'd0;
    logic [31:0] i_protect_word  = 32'd0;
    logic        i_serial_online = 1'b0;
    logic [15:0] i_alarm_count   = 16'd0;
    logic [7:0]  i_node_count    = 8'd0;
    logic [7:0]  i_online_count  = 8'd0;
    logic        i_ready         = 1'b0;

    // Block outputs
    logic [31:0] prdata;
    logic        pready;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_device;
    logic [1:0]  o_severity;
    logic [15:0] o_alert_code;
    logic        o_active;
    logic [2:0]  o_kind;
    logic        o_last;

    // Run control
    logic        calm       = 1'b0;     // no idling on either side while set
    logic        end_check  = 1'b0;
    logic [7:0]  crit_now   = CRIT_LEVEL_RESET;
    int          ready_hold = 0;
    int          alerts_pending;
    int          fail_count;

    device_health_alert_monitor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_alarm_level   (i_alarm_level),
        .i_fault_word    (i_fault_word),
        .i_alarm_word    (i_alarm_word),
        .i_protect_word  (i_protect_word),
        .i_serial_online (i_serial_online),
        .i_alarm_count   (i_alarm_count),
        .i_node_count    (i_node_count),
        .i_online_count  (i_online_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_device        (o_device),
        .o_severity      (o_severity),
        .o_alert_code    (o_alert_code),
        .o_active        (o_active),
        .o_kind          (o_kind),
        .o_last          (o_last)
    );

    dham_alert_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_mode          (i_mode),
        .i_alarm_level   (i_alarm_level),
        .i_fault_word    (i_fault_word),
        .i_alarm_word    (i_alarm_word),
        .i_protect_word  (i_protect_word),
        .i_serial_online (i_serial_online),
        .i_alarm_count   (i_alarm_count),
        .i_node_count    (i_node_count),
        .i_online_count  (i_online_count),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_device        (o_device),
        .i_severity      (o_severity),
        .i_alert_code    (o_alert_code),
        .i_active        (o_active),
        .i_kind          (o_kind),
        .i_last          (o_last),
        .i_end_check     (end_check),
        .o_pending       (alerts_pending),
        .o_fail_count    (fail_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle length: mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function automatic t_status_item make_item(input logic [2:0] mode, input logic [7:0] level,
                                               input logic [31:0] fault, input logic [31:0] alarm,
                                               input logic [31:0] protect, input logic serial,
                                               input logic [15:0] acount, input logic [7:0] nodes,
                                               input logic [7:0] online);
        t_status_item it;
        it.mode    = mode;
        it.level   = level;
        it.fault   = fault;
        it.alarm   = alarm;
        it.protect = protect;
        it.serial  = serial;
        it.acount  = acount;
        it.nodes   = nodes;
        it.online  = online;
        return it;
    endfunction

    // Every field random; fields the mode does not use stay as noise.
    function automatic t_status_item noise_item(input logic [2:0] mode);
        t_status_item it;
        it.mode    = mode;
        it.level   = 8'($urandom);
        it.fault   = $urandom;
        it.alarm   = $urandom;
        it.protect = $urandom;
        it.serial  = 1'($urandom);
        it.acount  = 16'($urandom);
        it.nodes   = 8'($urandom);
        it.online  = 8'($urandom);
        return it;
    endfunction

    // Random transfer, shaped so that statuses flip back and forth often.
    function automatic t_status_item rand_item();
        t_status_item it;
        logic [2:0]   mode;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 45)      mode = MODE_TICK;
        else if (r < 55) mode = MODE_BATTERY;
        else if (r < 65) mode = MODE_CHARGER;
        else if (r < 75) mode = MODE_CONVERTER;
        else if (r < 87) mode = MODE_RADIO;
        else if (r < 97) mode = MODE_BACKUP;
        else             mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        it = noise_item(mode);
        case (it.mode)
            MODE_BATTERY: begin
                r = $urandom_range(0, 9);
                if (r < 4)      it.level = 8'd0;
                else if (r < 6) it.level = crit_now;
                else if (r < 8) it.level = crit_now - 8'd1;
            end
            MODE_CHARGER: begin
                r = $urandom_range(0, 3);
                if (r == 0)      it.fault = 32'd0;
                else if (r == 1) it.fault[15:0] = 16'd0;   // upper bits only: no fault
                else if (r == 2) it.fault = $urandom_range(1, 3);
            end
            MODE_CONVERTER: begin
                r = $urandom_range(0, 3);
                if (r < 2)       it.fault = 32'd0;
                else if (r == 2) it.fault = 32'd1 << $urandom_range(0, 7);
            end
            MODE_RADIO: begin
                r = $urandom_range(0, 9);
                if (r < 4)       it.acount = 16'd0;
                else if (r < 6)  it.acount = 16'($urandom_range(1, 3));
                else if (r == 6) it.acount = 16'hFFFF;
                r = $urandom_range(0, 4);
                if (r == 0) begin
                    it.nodes = 8'd0;
                end else if (r < 4) begin
                    it.nodes  = 8'($urandom_range(1, 8));
                    it.online = 8'($urandom_range(0, 9));
                end
            end
            MODE_BACKUP: begin
                if ($urandom_range(0, 4) < 3) it.alarm   = 32'd0;
                if ($urandom_range(0, 4) < 3) it.protect = 32'd0;
                if ($urandom_range(0, 4) < 3) it.fault   = 32'd0;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Present one transfer, hold it until accepted, then idle for a while.
    // Call right after a rising edge; returns right after a rising edge.
    task automatic send_status(input t_status_item it);
        logic took;
        int   g;
        i_valid         <= 1'b1;
        i_mode          <= it.mode;
        i_alarm_level   <= it.level;
        i_fault_word    <= it.fault;
        i_alarm_word    <= it.alarm;
        i_protect_word  <= it.protect;
        i_serial_online <= it.serial;
        i_alarm_count   <= it.acount;
        i_node_count    <= it.nodes;
        i_online_count  <= it.online;
        // Sample ready mid-cycle, so the edge that follows is the transfer edge.
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted alert has come out,
    // then let the pipe run empty for the requested tail.
    task automatic drain_alerts(input int tail);
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (alerts_pending != 0 && waited < DRAIN_LIMIT);
        @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Register write in setup and access phases; bits above the register width carry noise.
    task automatic reg_write(input t_reg_idx idx, input logic [15:0] value);
        logic [31:0] data;
        data = $urandom;
        if (idx == REG_CONV_MASK || idx == REG_CRIT_LEVEL) data[7:0] = value[7:0];
        else data[15:0] = value;
        if (idx == REG_CRIT_LEVEL) crit_now = value[7:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic config_all(input logic [15:0] timeout, input logic [15:0] period,
                              input logic [7:0] mask, input logic [7:0] crit);
        reg_write(REG_TIMEOUT, timeout);
        reg_write(REG_PERIOD, period);
        reg_write(REG_CONV_MASK, {8'd0, mask});
        reg_write(REG_CRIT_LEVEL, {8'd0, crit});
    endtask

    // Alert side: stall at random, with runs of steady readiness between stalls.
    always @(posedge i_clk) begin : ready_gen
        int g;
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                i_ready    <= 1'b0;
                ready_hold = g - 1;
            end else begin
                i_ready    <= 1'b1;
                ready_hold = $urandom_range(0, 3);
            end
        end
    end

    initial begin : stimulus
        t_status_item it;
        int           sent;
        int           burst;
        logic [15:0]  t_val;
        logic [15:0]  p_val;
        logic [7:0]   m_val;
        logic [7:0]   c_val;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: short timeout and period so checks come quickly;
        // mask and alarm level keep their reset values here.
        reg_write(REG_TIMEOUT, 16'd2);
        reg_write(REG_PERIOD, 16'd2);
        // Battery: same level gives nothing, then critical, warning, and the
        // return to zero, which still reports as a warning.
        send_status(make_item(MODE_BATTERY, 8'd0, 32'd0, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_BATTERY, 8'hFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_BATTERY, 8'd1, 32'h00001234, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_BATTERY, 8'd0, 32'd0, 0, 0, 0, 0, 0, 0));
        // Charger: only the low half of the fault word counts.
        send_status(make_item(MODE_CHARGER, 0, 32'hFFFF0000, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_CHARGER, 0, 32'h0001FFFF, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_CHARGER, 0, 32'd0, 0, 0, 0, 0, 0, 0));
        // Converter: a masked-off bit is no fault.
        send_status(make_item(MODE_CONVERTER, 0, 32'h00000004, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_CONVERTER, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_CONVERTER, 0, 32'd0, 0, 0, 0, 0, 0, 0));
        // Radio: serial online with temperature and node alerts raised, then serial lost
        // with both cleared, then more online nodes than known nodes, which is not missing.
        send_status(make_item(MODE_RADIO, 0, 0, 0, 0, 1'b1, 16'hFFFF, 8'hFF, 8'd0));
        send_status(make_item(MODE_RADIO, 0, 0, 0, 0, 1'b0, 16'd0, 8'd0, 8'd0));
        send_status(make_item(MODE_RADIO, 0, 0, 0, 0, 1'b0, 16'd0, 8'd5, 8'd7));
        // Backup: each word alone makes it abnormal.
        send_status(make_item(MODE_BACKUP, 0, 0, 32'h80000000, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_BACKUP, 0, 0, 0, 32'h00000001, 0, 0, 0, 0));
        send_status(make_item(MODE_BACKUP, 0, 0, 0, 0, 0, 0, 0, 0));
        send_status(make_item(MODE_BACKUP, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));
        // Unused modes change nothing.
        send_status(noise_item(MODE_SPARE_6));
        send_status(noise_item(MODE_SPARE_7));
        // All five devices go online at the first check, offline at the next.
        repeat (4) send_status(noise_item(MODE_TICK));
        send_status(make_item(MODE_RADIO, 0, 0, 0, 0, 1'b0, 16'd0, 8'd0, 8'd0));
        repeat (2) send_status(noise_item(MODE_TICK));

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_alerts(TAIL_CYCLES);
            case (p)
                0: begin
                    t_val = 16'd0;     p_val = 16'd1;  m_val = 8'hFF; c_val = 8'd0;
                end
                1: begin
                    // zero period acts as one
                    t_val = 16'd65534; p_val = 16'd0;  m_val = 8'h00; c_val = 8'hFF;
                end
                default: begin
                    t_val = 16'($urandom_range(0, 10));
                    p_val = 16'($urandom_range(1, 5));
                    m_val = 8'($urandom);
                    c_val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
                end
            endcase
            config_all(t_val, p_val, m_val, c_val);
            calm = (p == 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0) begin
                    // run of ticks to push devices past their timeout
                    burst = $urandom_range(5, 30);
                    repeat (burst) send_status(noise_item(MODE_TICK));
                    sent += burst;
                end else begin
                    it = rand_item();
                    send_status(it);
                    if (it.mode <= MODE_BACKUP) sent++;
                end
                // hold off now and then until every alert is out
                if ($urandom_range(0, 39) == 0) drain_alerts(0);
            end
            calm = 1'b0;
        end

        drain_alerts(TAIL_CYCLES);
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** device_health_alert_monitor: PASSED **");
        end else begin
            $display("** device_health_alert_monitor: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("** device_health_alert_monitor: FAILED **");
        $finish;
    end

endmodule
